@@ rtl/uvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int QUO_W        = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS    = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_PHI_START = 3'd3,
    CFG_PHI_LEN   = 3'd4,
    CFG_THE_START = 3'd5,
    CFG_THE_LEN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        en;
    logic        vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [19:0] vindex;
    logic        quad;
  } vtx_meta_t;

endpackage

`default_nettype wire

@@ rtl/uvs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage
module uvs_div #(
  parameter int SegBits = 10,
  parameter int MetaW   = 1
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  uvs_pkg::pipe_ctl_t       ctl_i,
  input  wire  [SegBits-1:0]       num_i,
  input  wire  [SegBits-1:0]       den_i,
  input  wire  [MetaW-1:0]         meta_i,
  output logic                     vld_o,
  output logic [uvs_pkg::QUO_W-1:0] quo_o,
  output logic [MetaW-1:0]         meta_o
);

  localparam int QB = uvs_pkg::QUO_W;
  localparam int DW = SegBits + 16;

  logic [SegBits-1:0] rem_q  [0:QB];
  logic [QB-1:0]      low_q  [0:QB];
  logic [QB-1:0]      quo_q  [0:QB];
  logic [MetaW-1:0]   meta_q [0:QB];
  logic               vld_q  [0:QB];

  logic [DW-1:0] dividend_w;
  assign dividend_w = {num_i, 16'd0} + DW'(den_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0]  <= SegBits'(dividend_w >> QB);
      low_q[0]  <= dividend_w[QB-1:0];
      quo_q[0]  <= '0;
      meta_q[0] <= meta_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [SegBits:0] trial_w;
    logic             ge_w;
    assign trial_w = {rem_q[k], low_q[k][QB-1]};
    assign ge_w    = trial_w >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k+1]  <= ge_w ? SegBits'(trial_w - {1'b0, den_i}) : SegBits'(trial_w);
        low_q[k+1]  <= {low_q[k][QB-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][QB-2:0], ge_w};
        meta_q[k+1] <= meta_q[k];
      end
    end
  end

  assign vld_o  = vld_q[QB];
  assign quo_o  = quo_q[QB];
  assign meta_o = meta_q[QB];

endmodule

`default_nettype wire

@@ rtl/uvs_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

// two-lane rotation CORDIC, one iteration per stage
module uvs_cordic #(
  parameter int MetaW = 55
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  uvs_pkg::pipe_ctl_t  ctl_i,
  input  wire  [31:0]         ang_a_i,
  input  wire  [31:0]         ang_b_i,
  input  wire  [MetaW-1:0]    meta_i,
  output logic                vld_o,
  output logic signed [31:0]  cos_a_o,
  output logic signed [31:0]  sin_a_o,
  output logic signed [31:0]  cos_b_o,
  output logic signed [31:0]  sin_b_o,
  output logic [MetaW-1:0]    meta_o
);

  localparam int N  = uvs_pkg::CORDIC_STEPS;
  localparam int CW = uvs_pkg::CORDIC_W;

  logic signed [CW-1:0] x_q [0:N][2];
  logic signed [CW-1:0] y_q [0:N][2];
  logic signed [CW-1:0] z_q [0:N][2];
  logic [1:0]           qd_q [0:N][2];
  logic [MetaW-1:0]     meta_q [0:N];
  logic                 vld_q [0:N];

  logic [31:0] ang_w  [2];
  logic [31:0] sum_w  [2];
  logic [1:0]  qd_w   [2];
  logic [31:0] rest_w [2];

  assign ang_w[0] = ang_a_i;
  assign ang_w[1] = ang_b_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum_w[l]  = ang_w[l] + 32'h2000_0000;
      qd_w[l]   = sum_w[l][31:30];
      rest_w[l] = ang_w[l] - {qd_w[l], 30'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int l = 0; l < 2; l++) begin
        x_q[0][l]  <= uvs_pkg::CORDIC_GAIN;
        y_q[0][l]  <= '0;
        z_q[0][l]  <= CW'($signed(rest_w[l]));
        qd_q[0][l] <= qd_w[l];
      end
      meta_q[0] <= meta_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATAN = $signed({2'b00, uvs_pkg::ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int l = 0; l < 2; l++) begin
          if (!z_q[i][l][CW-1]) begin
            x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] - ATAN;
          end else begin
            x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] + ATAN;
          end
          qd_q[i+1][l] <= qd_q[i][l];
        end
        meta_q[i+1] <= meta_q[i];
      end
    end
  end

  logic signed [CW-1:0] c_w [2];
  logic signed [CW-1:0] s_w [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (qd_q[N][l])
        2'd0: begin c_w[l] = x_q[N][l];  s_w[l] = y_q[N][l];  end
        2'd1: begin c_w[l] = -y_q[N][l]; s_w[l] = x_q[N][l];  end
        2'd2: begin c_w[l] = -x_q[N][l]; s_w[l] = -y_q[N][l]; end
        default: begin c_w[l] = y_q[N][l]; s_w[l] = -x_q[N][l]; end
      endcase
    end
  end

  logic               vld_out_q;
  logic [MetaW-1:0]   meta_out_q;
  logic signed [31:0] ca_q, sa_q, cb_q, sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_out_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ca_q       <= c_w[0][31:0];
      sa_q       <= s_w[0][31:0];
      cb_q       <= c_w[1][31:0];
      sb_q       <= s_w[1][31:0];
      meta_out_q <= meta_q[N];
    end
  end

  assign vld_o   = vld_out_q;
  assign cos_a_o = ca_q;
  assign sin_a_o = sa_q;
  assign cos_b_o = cb_q;
  assign sin_b_o = sb_q;
  assign meta_o  = meta_out_q;

endmodule

`default_nettype wire

@@ rtl/uv_sphere_vertex_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | column_i, row_i
// out     | output    | out_valid_o/out_ready_i | pos_*, tex_*, normal_*, vertex_index, quad_start
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One transaction per cycle in while in_ready_o is high; the pipeline has 18 divider
// stages (input register and 17 quotient bits), one angle multiply, 26 CORDIC
// stages and three multiply/round stages.
// Every stage advances when the output register is empty or being taken.
// Reset clears valid bits and loads the configuration defaults.

module uv_sphere_vertex_generator #(
  parameter int SEGMENT_BITS = 10
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_idx_i,
  input  wire  [16:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [9:0]         column_i,
  input  wire  [9:0]         row_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [19:0]        vertex_index_o,
  output logic               quad_start_o
);

  localparam int SB    = SEGMENT_BITS;
  localparam int MetaW = $bits(uvs_pkg::vtx_meta_t);

  // configuration
  logic [15:0] radius_q;
  logic [9:0]  ws_q, hs_q;
  logic [15:0] phi_st_q, the_st_q;
  logic [16:0] phi_len_q, the_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 16'd256;
      ws_q      <= 10'd32;
      hs_q      <= 10'd16;
      phi_st_q  <= 16'd0;
      phi_len_q <= 17'd65536;
      the_st_q  <= 16'd0;
      the_len_q <= 17'd32768;
    end else if (cfg_we_i) begin
      unique case (uvs_pkg::cfg_idx_e'(cfg_idx_i))
        uvs_pkg::CFG_RADIUS:    radius_q  <= cfg_data_i[15:0];
        uvs_pkg::CFG_WIDTH:     ws_q      <= cfg_data_i[9:0];
        uvs_pkg::CFG_HEIGHT:    hs_q      <= cfg_data_i[9:0];
        uvs_pkg::CFG_PHI_START: phi_st_q  <= cfg_data_i[15:0];
        uvs_pkg::CFG_PHI_LEN:   phi_len_q <= cfg_data_i;
        uvs_pkg::CFG_THE_START: the_st_q  <= cfg_data_i[15:0];
        uvs_pkg::CFG_THE_LEN:   the_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic en;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // grid clamp
  logic [15:0]   ws_x, hs_x, col_x, row_x;
  logic [SB-1:0] ws_m, hs_m, col_m, row_m, ws_n, hs_n, col_c, row_c;
  logic          quad_w;

  assign ws_x  = 16'(ws_q);
  assign hs_x  = 16'(hs_q);
  assign col_x = 16'(column_i);
  assign row_x = 16'(row_i);
  assign ws_m  = ws_x[SB-1:0];
  assign hs_m  = hs_x[SB-1:0];
  assign col_m = col_x[SB-1:0];
  assign row_m = row_x[SB-1:0];
  assign ws_n  = (ws_m == '0) ? SB'(1) : ws_m;
  assign hs_n  = (hs_m == '0) ? SB'(1) : hs_m;
  assign quad_w = (col_m < ws_n) && (row_m < hs_n);
  assign col_c  = (col_m > ws_n) ? ws_n : col_m;
  assign row_c  = (row_m > hs_n) ? hs_n : row_m;

  uvs_pkg::pipe_ctl_t in_ctl;
  assign in_ctl.en  = en;
  assign in_ctl.vld = in_valid_i;

  logic            du_vld, dv_vld;
  logic [16:0]     u_w, v_w;
  logic [2*SB-1:0] du_meta;
  logic            dv_meta;

  uvs_div #(.SegBits(SB), .MetaW(2 * SB)) u_div_u (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (in_ctl),
    .num_i  (col_c),
    .den_i  (ws_n),
    .meta_i ({row_c, col_c}),
    .vld_o  (du_vld),
    .quo_o  (u_w),
    .meta_o (du_meta)
  );

  uvs_div #(.SegBits(SB), .MetaW(1)) u_div_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (in_ctl),
    .num_i  (row_c),
    .den_i  (hs_n),
    .meta_i (quad_w),
    .vld_o  (dv_vld),
    .quo_o  (v_w),
    .meta_o (dv_meta)
  );

  // angle stage
  logic [SB-1:0] d_row, d_col;
  logic [33:0]   phi_prod, the_prod, vidx_prod;
  assign d_row     = du_meta[2*SB-1:SB];
  assign d_col     = du_meta[SB-1:0];
  assign phi_prod  = 34'(u_w) * 34'(phi_len_q);
  assign the_prod  = 34'(v_w) * 34'(the_len_q);
  assign vidx_prod = 34'(d_row) * (34'(ws_n) + 34'd1) + 34'(d_col);

  logic                 a_vld_q;
  logic [31:0]          phi_q, the_q;
  uvs_pkg::vtx_meta_t   a_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= du_vld && dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q           <= {phi_st_q, 16'd0} + phi_prod[31:0];
      the_q           <= {the_st_q, 16'd0} + the_prod[31:0];
      a_meta_q.tex_u  <= u_w;
      a_meta_q.tex_v  <= v_w;
      a_meta_q.vindex <= vidx_prod[19:0];
      a_meta_q.quad   <= dv_meta;
    end
  end

  uvs_pkg::pipe_ctl_t a_ctl;
  assign a_ctl.en  = en;
  assign a_ctl.vld = a_vld_q;

  logic               c_vld;
  logic signed [31:0] cp, sp, ct, st;
  logic [MetaW-1:0]   c_meta;

  uvs_cordic #(.MetaW(MetaW)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (a_ctl),
    .ang_a_i (phi_q),
    .ang_b_i (the_q),
    .meta_i  (a_meta_q),
    .vld_o   (c_vld),
    .cos_a_o (cp),
    .sin_a_o (sp),
    .cos_b_o (ct),
    .sin_b_o (st),
    .meta_o  (c_meta)
  );

  // direction products
  logic signed [63:0] pdx_w, pdz_w;
  assign pdx_w = cp * st + 64'sd536870912;
  assign pdz_w = sp * st + 64'sd536870912;

  logic                m_vld_q;
  logic signed [31:0]  dx_q, dz_q, ct_q;
  uvs_pkg::vtx_meta_t  m_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q     <= pdx_w[61:30];
      dz_q     <= pdz_w[61:30];
      ct_q     <= ct;
      m_meta_q <= uvs_pkg::vtx_meta_t'(c_meta);
    end
  end

  function automatic logic [15:0] to_normal(input logic signed [31:0] q30);
    logic signed [32:0] t;
    logic signed [32:0] n;
    t = 33'(q30) + 33'sd32768;
    n = t >>> 16;
    if (n > 33'sd16384) begin
      return 16'sd16384;
    end else if (n < -33'sd16384) begin
      return -16'sd16384;
    end
    return n[15:0];
  endfunction

  function automatic logic [16:0] to_pos(input logic signed [48:0] prod);
    logic signed [48:0] t;
    logic signed [48:0] p;
    t = prod + 49'sd536870912;
    p = t >>> 30;
    if (p > 49'sd65535) begin
      return 17'sd65535;
    end else if (p < -49'sd65535) begin
      return -17'sd65535;
    end
    return p[16:0];
  endfunction

  // radius products and normals
  logic signed [16:0] rad_s;
  assign rad_s = $signed({1'b0, radius_q});

  logic                p_vld_q;
  logic signed [48:0]  px_q, py_q, pz_q;
  logic [15:0]         nx_q, ny_q, nz_q;
  uvs_pkg::vtx_meta_t  p_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q     <= rad_s * dx_q;
      py_q     <= rad_s * ct_q;
      pz_q     <= rad_s * dz_q;
      nx_q     <= to_normal(dx_q);
      ny_q     <= to_normal(ct_q);
      nz_q     <= to_normal(dz_q);
      p_meta_q <= m_meta_q;
    end
  end

  // output register
  logic [16:0]        ox_q, oy_q, oz_q;
  logic [15:0]        onx_q, ony_q, onz_q;
  uvs_pkg::vtx_meta_t o_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q     <= to_pos(px_q);
      oy_q     <= to_pos(py_q);
      oz_q     <= to_pos(pz_q);
      onx_q    <= nx_q;
      ony_q    <= ny_q;
      onz_q    <= nz_q;
      o_meta_q <= p_meta_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pos_x_o        = ox_q;
  assign pos_y_o        = oy_q;
  assign pos_z_o        = oz_q;
  assign normal_x_o     = onx_q;
  assign normal_y_o     = ony_q;
  assign normal_z_o     = onz_q;
  assign tex_u_o        = o_meta_q.tex_u;
  assign tex_v_o        = o_meta_q.tex_v;
  assign vertex_index_o = o_meta_q.vindex;
  assign quad_start_o   = o_meta_q.quad;

  a_quad_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quad_start_o |-> (tex_u_o < 17'd65536) && (tex_v_o < 17'd65536))
    else $error("quad start on grid edge");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'd65536) && (tex_v_o <= 17'd65536))
    else $error("texture coordinate above one");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

endmodule

`default_nettype wire

@@ test/uv_sphere_vertex_generator_tb.sv @@
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_tb;

  localparam int SEG_BITS = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [19:0] vindex;
    logic        quad;
  } vertex_t;

  class vertex_scoreboard;
    logic [15:0] radius;
    logic [9:0]  wseg;
    logic [9:0]  hseg;
    logic [15:0] phi_start;
    logic [16:0] phi_len;
    logic [15:0] the_start;
    logic [16:0] the_len;
    vertex_t     expected_q[$];
    int          mismatches;

    function new();
      radius    = 16'd256;
      wseg      = 10'd32;
      hseg      = 10'd16;
      phi_start = 16'd0;
      phi_len   = 17'd65536;
      the_start = 16'd0;
      the_len   = 17'd32768;
      mismatches = 0;
    endfunction

    function void set_reg(uvs_pkg::cfg_idx_e idx, logic [16:0] value);
      case (idx)
        uvs_pkg::CFG_RADIUS:    radius    = value[15:0];
        uvs_pkg::CFG_WIDTH:     wseg      = value[9:0];
        uvs_pkg::CFG_HEIGHT:    hseg      = value[9:0];
        uvs_pkg::CFG_PHI_START: phi_start = value[15:0];
        uvs_pkg::CFG_PHI_LEN:   phi_len   = value;
        uvs_pkg::CFG_THE_START: the_start = value[15:0];
        uvs_pkg::CFG_THE_LEN:   the_len   = value;
        default: ;
      endcase
    endfunction

    function void sin_cos(logic [31:0] ang, output longint c, output longint s);
      logic [31:0] q;
      logic [31:0] rest;
      longint x, y, z, dx, dy;
      q = ((ang + 32'h20000000) >> 30) & 32'd3;
      rest = ang - (q << 30);
      z = longint'($signed(rest));
      x = 652032874;
      y = 0;
      for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - longint'(uvs_pkg::ATAN_TURNS[i]);
        end else begin
          x = x + dx; y = y - dy; z = z + longint'(uvs_pkg::ATAN_TURNS[i]);
        end
      end
      case (q)
        0: begin c = x;  s = y;  end
        1: begin c = -y; s = x;  end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic [15:0] to_normal(longint q30);
      longint n;
      n = (q30 + (longint'(1) << 15)) >>> 16;
      if (n > 16384) n = 16384;
      if (n < -16384) n = -16384;
      return n[15:0];
    endfunction

    function logic [16:0] to_pos(longint q30);
      longint p;
      p = (longint'(radius) * q30 + (longint'(1) << 29)) >>> 30;
      if (p > 65535) p = 65535;
      if (p < -65535) p = -65535;
      return p[16:0];
    endfunction

    function void note_input(logic [9:0] column, logic [9:0] row);
      longint ws, hs, c, r, u, v, phi_full, the_full;
      longint cp, sp, ct, st, dx, dz, idx;
      vertex_t e;
      ws = wseg & ((1 << SEG_BITS) - 1);
      hs = hseg & ((1 << SEG_BITS) - 1);
      c = column & ((1 << SEG_BITS) - 1);
      r = row & ((1 << SEG_BITS) - 1);
      if (ws == 0) ws = 1;
      if (hs == 0) hs = 1;
      e.quad = (c < ws) && (r < hs);
      if (c > ws) c = ws;
      if (r > hs) r = hs;
      u = (c * 65536 + ws / 2) / ws;
      v = (r * 65536 + hs / 2) / hs;
      phi_full = (longint'(phi_start) << 16) + u * longint'(phi_len);
      the_full = (longint'(the_start) << 16) + v * longint'(the_len);
      sin_cos(phi_full[31:0], cp, sp);
      sin_cos(the_full[31:0], ct, st);
      dx = (cp * st + (longint'(1) << 29)) >>> 30;
      dz = (sp * st + (longint'(1) << 29)) >>> 30;
      idx = r * (ws + 1) + c;
      e.pos_x = to_pos(dx);
      e.pos_y = to_pos(ct);
      e.pos_z = to_pos(dz);
      e.tex_u = u[16:0];
      e.tex_v = v[16:0];
      e.normal_x = to_normal(dx);
      e.normal_y = to_normal(ct);
      e.normal_z = to_normal(dz);
      e.vindex = idx[19:0];
      expected_q = {expected_q, e};
    endfunction

    function void check_result(vertex_t got);
      vertex_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  column;
  logic [9:0]  row;
  logic        out_valid;
  logic        out_ready;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic [16:0] tex_u, tex_v;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [19:0] vertex_index;
  logic        quad_start;

  vertex_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles;

  uv_sphere_vertex_generator #(.SEGMENT_BITS(SEG_BITS)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .column_i(column), .row_i(row),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z),
    .tex_u_o(tex_u), .tex_v_o(tex_v),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .vertex_index_o(vertex_index), .quad_start_o(quad_start)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(column, row);
      if (out_valid && out_ready)
        sb.check_result({pos_x, pos_y, pos_z, tex_u, tex_v,
                         normal_x, normal_y, normal_z, vertex_index, quad_start});
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(uvs_pkg::cfg_idx_e idx, logic [16:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic load_sphere(logic [16:0] rad, logic [16:0] ws, logic [16:0] hs,
                             logic [16:0] ps, logic [16:0] pl,
                             logic [16:0] ts, logic [16:0] tl);
    drain();
    write_reg(uvs_pkg::CFG_RADIUS, rad);
    write_reg(uvs_pkg::CFG_WIDTH, ws);
    write_reg(uvs_pkg::CFG_HEIGHT, hs);
    write_reg(uvs_pkg::CFG_PHI_START, ps);
    write_reg(uvs_pkg::CFG_PHI_LEN, pl);
    write_reg(uvs_pkg::CFG_THE_START, ts);
    write_reg(uvs_pkg::CFG_THE_LEN, tl);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [9:0] c, logic [9:0] r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    column   <= c;
    row      <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [16:0] pick(int lo, int hi);
    case ($urandom_range(5))
      0: return 17'(lo);
      1: return 17'(hi);
      default: return 17'($urandom_range(hi, lo));
    endcase
  endfunction

  initial begin
    int ws, hs, total;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    column = '0;
    row = '0;
    out_ready = 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 64;
    stall_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, grid edges and beyond
    send_point(0, 0);
    send_point(32, 16);
    send_point(31, 15);
    send_point(33, 0);
    send_point(0, 17);
    send_point(1023, 1023);
    send_point(16, 8);
    send_point(8, 4);
    // zero segments, minimum radius, zero sweeps
    load_sphere(1, 0, 0, 0, 0, 0, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1023, 0);
    // largest radius, largest grid, sweeps above one turn
    load_sphere(65535, 1023, 1023, 65535, 131071, 65535, 131071);
    send_point(0, 0);
    send_point(1023, 1023);
    send_point(1022, 1022);
    send_point(511, 512);
    send_point(10'h2AA, 10'h155);
    send_point(10'h155, 10'h2AA);
    load_sphere(65535, 7, 5, 0, 65536, 0, 32768);
    send_point(3, 2);
    send_point(7, 5);
    send_point(6, 4);

    total = 0;
    while (total < 1530) begin
      if (total == 510) begin
        tx_idle_pct = 64; rx_idle_pct = 37;
      end else if (total == 1020) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (total % 170 == 0) begin
        if ($urandom_range(1))
          load_sphere(pick(1, 65535), pick(0, 40), pick(0, 40), pick(0, 65535),
                      pick(0, 131071), pick(0, 65535), pick(0, 131071));
        else
          load_sphere(pick(1, 65535), pick(0, 1023), pick(0, 1023), pick(0, 65535),
                      pick(0, 131071), pick(0, 65535), pick(0, 131071));
      end
      ws = (sb.wseg == 0) ? 1 : sb.wseg;
      hs = (sb.hseg == 0) ? 1 : sb.hseg;
      if ($urandom_range(9) < 8)
        send_point(10'($urandom_range((ws + 1 > 1023) ? 1023 : ws + 1)),
                   10'($urandom_range((hs + 1 > 1023) ? 1023 : hs + 1)));
      else
        send_point(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      total++;
    end
    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
